>>> src/x256r_pkg.sv
package x256r_pkg;

    localparam int WORD_W  = 64;
    localparam int RANGE_W = 32;
    localparam int SPAN_W  = RANGE_W + 1;
    localparam int NUM_WORDS = 4;
    localparam int IDX_W   = $clog2(NUM_WORDS);

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    // xoshiro256++ constants
    localparam int OUT_ROT   = 23;
    localparam int W1_SHIFT  = 17;
    localparam int W3_ROT    = 45;

    // item function codes
    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_ADD,
        ST_EXP_MUL1,
        ST_EXP_MUL2,
        ST_DRAW_SUM,
        ST_DRAW_OUT,
        ST_REM_START,
        ST_REM_WAIT,
        ST_DONE
    } state_t;

endpackage

>>> src/x256r_mul.sv
// bit-serial multiplier, low word of the product, one multiplier bit per cycle
module x256r_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [x256r_pkg::WORD_W-1:0]   op_a,
    input  logic [x256r_pkg::WORD_W-1:0]   op_b,
    output logic [x256r_pkg::WORD_W-1:0]   product,
    output logic                           done
);
    localparam int CNT_W = $clog2(x256r_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(x256r_pkg::WORD_W - 1);

    logic [x256r_pkg::WORD_W-1:0] a_reg;
    logic [x256r_pkg::WORD_W-1:0] b_reg;
    logic [x256r_pkg::WORD_W-1:0] acc_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

>>> src/x256r_rem.sv
// bit-serial restoring remainder, one dividend bit per cycle
module x256r_rem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [x256r_pkg::WORD_W-1:0]   dividend,
    input  logic [x256r_pkg::SPAN_W-1:0]   divisor,
    output logic [x256r_pkg::SPAN_W-1:0]   remainder,
    output logic                           done
);
    localparam int CNT_W = $clog2(x256r_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(x256r_pkg::WORD_W - 1);

    logic [x256r_pkg::WORD_W-1:0] num_reg;
    logic [x256r_pkg::SPAN_W-1:0] div_reg;
    logic [x256r_pkg::SPAN_W-1:0] rem_reg;
    logic [x256r_pkg::SPAN_W-1:0] rem_next;
    logic [x256r_pkg::SPAN_W:0]   trial;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_comb begin
        trial = {rem_reg, num_reg[x256r_pkg::WORD_W-1]};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = x256r_pkg::SPAN_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[x256r_pkg::SPAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> src/xoshiro256pp_rng_with_range_top.sv
// xoshiro256++ generator with a ranged draw. A word with s_func = 0 reseeds the
// four 64-bit state words from s_seed_value through the splitmix64 expansion and
// gives no result; a word with s_func = 1 returns the raw 64-bit output, advances
// the state, and returns s_range_low + raw mod (s_range_high - s_range_low + 1),
// with the span taken exactly in 33 bits. When s_range_high < s_range_low the
// result flags m_range_error, m_ranged_value is zero and the state still moves.
// A draw runs the 64-step bit-serial remainder unit before m_valid rises (an
// inverted range skips it), and s_ready is high again in the same cycle that
// m_valid rises. A reseed runs the bit-serial 64-bit multiplier twice per state
// word. After reset the block runs the same expansion with seed zero and holds
// s_ready low until that expansion is done, before it takes its first word. One
// word is in work at a time; a finished result sits in the output register, so
// the next word is accepted while it waits, and a draw that finishes while that
// register is still full holds s_ready low until it frees.
module xoshiro256pp_rng_with_range_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [x256r_pkg::WORD_W-1:0]          s_seed_value,
    input  logic signed [x256r_pkg::RANGE_W-1:0]  s_range_low,
    input  logic signed [x256r_pkg::RANGE_W-1:0]  s_range_high,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [x256r_pkg::WORD_W-1:0]          m_raw_value,
    output logic signed [x256r_pkg::RANGE_W-1:0]  m_ranged_value,
    output logic                                  m_range_error
);
    localparam int W = x256r_pkg::WORD_W;
    localparam int R = x256r_pkg::RANGE_W;
    localparam int S = x256r_pkg::SPAN_W;

    x256r_pkg::state_t state_reg;
    x256r_pkg::state_t state_next;

    // generator state, written one word at a time during expansion
    logic [W-1:0] words_reg [x256r_pkg::NUM_WORDS];
    logic [x256r_pkg::IDX_W-1:0] word_idx_reg;
    logic [W-1:0] seed_reg;

    // draw datapath
    logic signed [R-1:0] lo_reg;
    logic signed [R-1:0] hi_reg;
    logic [W-1:0] sum_reg;
    logic [W-1:0] raw_reg;
    logic [S-1:0] span_reg;
    logic         err_reg;

    // output register
    logic         m_valid_reg;
    logic [W-1:0] m_raw_reg;
    logic [R-1:0] m_ranged_reg;
    logic         m_err_reg;

    // control
    logic         accept;
    logic         out_free;
    logic         out_load;
    logic         mul_start;
    logic         mul_done;
    logic         rem_start;
    logic         rem_done;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_prod;
    logic [S-1:0] rem_value;

    // splitmix64 helpers
    logic [W-1:0] seed_sum;
    logic [W-1:0] seed_mix;
    logic [W-1:0] prod_mix_b;
    logic [W-1:0] prod_mix_c;

    // xoshiro step
    logic [W-1:0] w0_new;
    logic [W-1:0] w1_new;
    logic [W-1:0] w2_new;
    logic [W-1:0] w3_xor;
    logic [W-1:0] w3_new;
    logic [W-1:0] sum_rot;
    logic [S-1:0] range_diff;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign seed_sum   = seed_reg + x256r_pkg::GOLDEN_STEP;
    assign seed_mix   = seed_sum ^ (seed_sum >> x256r_pkg::MIX_SHIFT_A);
    assign prod_mix_b = mul_prod ^ (mul_prod >> x256r_pkg::MIX_SHIFT_B);
    assign prod_mix_c = mul_prod ^ (mul_prod >> x256r_pkg::MIX_SHIFT_C);

    // next state words, all from the old words
    assign w2_new  = words_reg[2] ^ words_reg[0] ^ (words_reg[1] << x256r_pkg::W1_SHIFT);
    assign w3_xor  = words_reg[3] ^ words_reg[1];
    assign w1_new  = words_reg[1] ^ words_reg[2] ^ words_reg[0];
    assign w0_new  = words_reg[0] ^ w3_xor;
    assign w3_new  = (w3_xor << x256r_pkg::W3_ROT) | (w3_xor >> (W - x256r_pkg::W3_ROT));
    assign sum_rot = (sum_reg << x256r_pkg::OUT_ROT) | (sum_reg >> (W - x256r_pkg::OUT_ROT));

    // signed 33-bit difference; its sign bit is the range error
    assign range_diff = {hi_reg[R-1], hi_reg} - {lo_reg[R-1], lo_reg};

    x256r_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod),
        .done    (mul_done)
    );

    x256r_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (raw_reg),
        .divisor   (span_reg),
        .remainder (rem_value),
        .done      (rem_done)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            x256r_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == x256r_pkg::FUNC_RESEED) begin
                        state_next = x256r_pkg::ST_EXP_ADD;
                    end else begin
                        state_next = x256r_pkg::ST_DRAW_SUM;
                    end
                end
            end
            x256r_pkg::ST_EXP_ADD:  state_next = x256r_pkg::ST_EXP_MUL1;
            x256r_pkg::ST_EXP_MUL1: begin
                if (mul_done) state_next = x256r_pkg::ST_EXP_MUL2;
            end
            x256r_pkg::ST_EXP_MUL2: begin
                if (mul_done) begin
                    if (word_idx_reg == x256r_pkg::IDX_W'(x256r_pkg::NUM_WORDS - 1)) begin
                        state_next = x256r_pkg::ST_IDLE;
                    end else begin
                        state_next = x256r_pkg::ST_EXP_ADD;
                    end
                end
            end
            x256r_pkg::ST_DRAW_SUM: state_next = x256r_pkg::ST_DRAW_OUT;
            x256r_pkg::ST_DRAW_OUT: begin
                // inverted range skips the remainder
                if (range_diff[S-1]) begin
                    state_next = x256r_pkg::ST_DONE;
                end else begin
                    state_next = x256r_pkg::ST_REM_START;
                end
            end
            x256r_pkg::ST_REM_START: state_next = x256r_pkg::ST_REM_WAIT;
            x256r_pkg::ST_REM_WAIT: begin
                if (rem_done) state_next = x256r_pkg::ST_DONE;
            end
            x256r_pkg::ST_DONE: begin
                if (out_free) state_next = x256r_pkg::ST_IDLE;
            end
            default: state_next = x256r_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        mul_a     = prod_mix_b;
        mul_b     = x256r_pkg::MIX_MUL_B;
        rem_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            x256r_pkg::ST_IDLE:      s_ready = 1'b1;
            x256r_pkg::ST_EXP_ADD: begin
                mul_start = 1'b1;
                mul_a     = seed_mix;
                mul_b     = x256r_pkg::MIX_MUL_A;
            end
            x256r_pkg::ST_EXP_MUL1:  mul_start = mul_done;
            x256r_pkg::ST_REM_START: rem_start = 1'b1;
            x256r_pkg::ST_DONE:      out_load  = out_free;
            x256r_pkg::ST_EXP_MUL2,
            x256r_pkg::ST_DRAW_SUM,
            x256r_pkg::ST_DRAW_OUT,
            x256r_pkg::ST_REM_WAIT: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // reset state is the expansion of seed zero
            state_reg    <= x256r_pkg::ST_EXP_ADD;
            seed_reg     <= '0;
            word_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                x256r_pkg::ST_IDLE: begin
                    if (accept && s_func == x256r_pkg::FUNC_RESEED) begin
                        seed_reg     <= s_seed_value;
                        word_idx_reg <= '0;
                    end
                end
                x256r_pkg::ST_EXP_ADD:  seed_reg <= seed_sum;
                x256r_pkg::ST_EXP_MUL2: begin
                    if (mul_done) word_idx_reg <= word_idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            x256r_pkg::ST_IDLE: begin
                if (accept) begin
                    lo_reg <= s_range_low;
                    hi_reg <= s_range_high;
                end
            end
            x256r_pkg::ST_EXP_MUL2: begin
                if (mul_done) words_reg[word_idx_reg] <= prod_mix_c;
            end
            x256r_pkg::ST_DRAW_SUM: sum_reg <= words_reg[0] + words_reg[3];
            x256r_pkg::ST_DRAW_OUT: begin
                raw_reg      <= sum_rot + words_reg[0];
                span_reg     <= range_diff + 1'b1;
                err_reg      <= range_diff[S-1];
                words_reg[0] <= w0_new;
                words_reg[1] <= w1_new;
                words_reg[2] <= w2_new;
                words_reg[3] <= w3_new;
            end
            x256r_pkg::ST_DONE: begin
                if (out_load) begin
                    m_raw_reg    <= raw_reg;
                    m_err_reg    <= err_reg;
                    m_ranged_reg <= err_reg ? '0 : R'(lo_reg) + rem_value[R-1:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_raw_value    = m_raw_reg;
    assign m_ranged_value = m_ranged_reg;
    assign m_range_error  = m_err_reg;

endmodule

>>> src/x256r_checker.sv
module x256r_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [x256r_pkg::WORD_W-1:0]          m_raw_value,
    input logic signed [x256r_pkg::RANGE_W-1:0]  m_ranged_value,
    input logic                                  m_range_error
);

    // reset starts the seed expansion, nothing to accept or deliver
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready or valid right after reset");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    // inverted range gives zero
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_ranged_value == '0)
        else $error("ranged value not zero on range error");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_raw_value)
            && $stable(m_ranged_value) && $stable(m_range_error))
        else $error("stalled result changed");

endmodule

bind xoshiro256pp_rng_with_range_top x256r_checker u_x256r_checker (.*);

>>> tb/xoshiro256pp_rng_with_range_top_tb.sv
`timescale 1ns / 1ps

module xoshiro256pp_rng_with_range_top_tb;

    // run length guard and the quiet time after the last expected word
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 700;
    localparam int RANDOM_WORDS = 450;

    // splitmix64 constants, kept locally for the predictor
    localparam logic [63:0] SM_INCREMENT = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL_FIRST = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL_SECOND = 64'h94d049bb133111eb;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

    // one expected draw result
    typedef struct {
        logic [63:0]        raw;
        logic signed [31:0] ranged;
        logic               err;
    } draw_result_t;

    // generator state copy plus the queue of draws still owed by the block
    class draw_checker;
        logic [63:0]  gen_words [4];
        draw_result_t pending_draws [$];
        int           errors;

        function new();
            errors = 0;
            load_seed(64'd0);
        endfunction

        function logic [63:0] rotl(logic [63:0] v, int n);
            return (v << n) | (v >> (64 - n));
        endfunction

        // splitmix64 expansion of one seed into four words
        function void load_seed(logic [63:0] seed);
            logic [63:0] z;
            for (int i = 0; i < 4; i++) begin
                seed = seed + SM_INCREMENT;
                z = seed;
                z = z ^ (z >> 30);
                z = z * SM_MUL_FIRST;
                z = z ^ (z >> 27);
                z = z * SM_MUL_SECOND;
                z = z ^ (z >> 31);
                gen_words[i] = z;
            end
        endfunction

        // xoshiro256++ output, then state step
        function logic [63:0] next_raw();
            logic [63:0] out;
            logic [63:0] shifted;
            out = rotl(gen_words[0] + gen_words[3], 23) + gen_words[0];
            shifted = gen_words[1] << 17;
            gen_words[2] = gen_words[2] ^ gen_words[0];
            gen_words[3] = gen_words[3] ^ gen_words[1];
            gen_words[1] = gen_words[1] ^ gen_words[2];
            gen_words[0] = gen_words[0] ^ gen_words[3];
            gen_words[2] = gen_words[2] ^ shifted;
            gen_words[3] = rotl(gen_words[3], 45);
            return out;
        endfunction

        function void note_word(logic func, logic [63:0] seed,
                                logic signed [31:0] lo, logic signed [31:0] hi);
            draw_result_t r;
            longint       lo64;
            longint       hi64;
            logic [63:0]  span;
            logic [63:0]  rem;
            logic [63:0]  sum;
            if (func == x256r_pkg::FUNC_RESEED) begin
                load_seed(seed);
                return;
            end
            r.raw = next_raw();
            lo64 = lo;
            hi64 = hi;
            if (hi64 < lo64) begin
                r.ranged = '0;
                r.err = 1'b1;
            end else begin
                span = hi64 - lo64 + 1;
                rem = r.raw % span;
                sum = lo64 + rem;
                r.ranged = sum[31:0];
                r.err = 1'b0;
            end
            pending_draws.push_back(r);
        endfunction

        function void check_result(logic [63:0] raw, logic signed [31:0] ranged,
                                   logic err);
            draw_result_t e;
            if (pending_draws.size() == 0) begin
                $display("%0t: unexpected result word raw %h ranged %h error %b",
                         $time, raw, ranged, err);
                errors++;
                return;
            end
            e = pending_draws.pop_front();
            if (raw !== e.raw) begin
                $display("%0t: raw_value mismatch expected %h actual %h",
                         $time, e.raw, raw);
                errors++;
            end
            if (ranged !== e.ranged) begin
                $display("%0t: ranged_value mismatch expected %h actual %h",
                         $time, e.ranged, ranged);
                errors++;
            end
            if (err !== e.err) begin
                $display("%0t: range_error mismatch expected %b actual %b",
                         $time, e.err, err);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [63:0]        s_seed_value;
    logic signed [31:0] s_range_low;
    logic signed [31:0] s_range_high;
    logic               m_valid;
    logic               m_ready;
    logic [63:0]        m_raw_value;
    logic signed [31:0] m_ranged_value;
    logic               m_range_error;

    draw_checker checker_h;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          cycle_count;

    xoshiro256pp_rng_with_range_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_seed_value   (s_seed_value),
        .s_range_low    (s_range_low),
        .s_range_high   (s_range_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_raw_value    (m_raw_value),
        .m_ranged_value (m_ranged_value),
        .m_range_error  (m_range_error)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // receiver backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor: results are checked before the same-edge input is noted,
    // since a result leaving now always belongs to an older word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                checker_h.check_result(m_raw_value, m_ranged_value, m_range_error);
            if (s_valid && s_ready)
                checker_h.note_word(s_func, s_seed_value, s_range_low, s_range_high);
        end
    end

    // timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("xoshiro256pp_rng_with_range_top_tb NOT OK");
            $finish;
        end
    end

    // present one word and hold it until accepted; called and left at a falling edge
    task automatic send_word(input logic func, input logic [63:0] seed,
                             input logic signed [31:0] lo, input logic signed [31:0] hi);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_seed_value <= seed;
        s_range_low  <= lo;
        s_range_high <= hi;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic draw(input logic signed [31:0] lo, input logic signed [31:0] hi);
        send_word(x256r_pkg::FUNC_DRAW, {$urandom, $urandom}, lo, hi);
    endtask

    task automatic reseed(input logic [63:0] seed);
        send_word(x256r_pkg::FUNC_RESEED, seed, $urandom, $urandom);
    endtask

    // range mix: narrow spans most often, some wide, full, single-value and inverted
    task automatic pick_range(output logic signed [31:0] lo, output logic signed [31:0] hi);
        longint a;
        longint b;
        a = longint'($signed($urandom));
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                b = a + $urandom_range(0, 200);
                if (b > longint'(S32_MAX))
                    b = S32_MAX;
            end
            4, 5: b = longint'($signed($urandom));
            6: begin
                a = S32_MIN;
                b = S32_MAX;
            end
            7: b = a;
            8: begin
                b = a + (longint'(1) << $urandom_range(0, 31)) - 1;
                if (b > longint'(S32_MAX))
                    b = S32_MAX;
            end
            default: begin
                b = a - $urandom_range(1, 1000);
                if (b < longint'(S32_MIN)) begin
                    a = S32_MIN + 1;
                    b = S32_MIN;
                end
            end
        endcase
        lo = a[31:0];
        hi = b[31:0];
    endtask

    // sender waits for every owed result before going on
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (checker_h.pending_draws.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [63:0]        seed;

        checker_h    = new();
        cycle_count  = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = x256r_pkg::FUNC_RESEED;
        s_seed_value = '0;
        s_range_low  = '0;
        s_range_high = '0;
        m_ready      = 1'b0;

        // reset asserted at start, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, starting from the seed-zero reset state
        draw(32'sd0, 32'sd0);
        draw(S32_MIN, S32_MAX);           // full signed span
        draw(32'sd5, -32'sd5);            // inverted range
        draw(S32_MAX, S32_MIN);           // inverted at the extremes
        draw(S32_MAX, S32_MAX);
        draw(S32_MIN, S32_MIN);
        draw(32'sd0, 32'sd1);
        draw(-32'sd1, 32'sd0);
        draw(32'sd0, S32_MAX);
        draw(S32_MIN, -32'sd1);
        reseed(64'd0);                    // same as the reset state
        draw(S32_MIN, S32_MAX);
        reseed(64'hffff_ffff_ffff_ffff);
        draw(32'sd1, 32'sd6);
        reseed(64'h8000_0000_0000_0000);
        draw(-32'sd100, 32'sd100);
        send_word(x256r_pkg::FUNC_RESEED, 64'h0123_4567_89ab_cdef, S32_MAX, S32_MIN);
        draw(S32_MIN + 1, S32_MAX);
        draw(S32_MIN, S32_MAX - 1);
        reseed(64'h5555_5555_aaaa_aaaa);
        draw(S32_MAX - 1, S32_MAX);
        draw(32'sd3, 32'sd2);

        // random part in three idling phases
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 0) begin
                tx_idle_pct = 14;
                rx_idle_pct = 88;
            end else if (i == RANDOM_WORDS / 3) begin
                tx_idle_pct = 88;
                rx_idle_pct = 14;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == RANDOM_WORDS / 2)
                wait_for_drain();
            if ($urandom_range(99) < 8) begin
                case ($urandom_range(5))
                    0: seed = 64'd0;
                    1: seed = 64'hffff_ffff_ffff_ffff;
                    default: seed = {$urandom, $urandom};
                endcase
                reseed(seed);
            end else begin
                pick_range(lo, hi);
                draw(lo, hi);
            end
        end
        s_valid <= 1'b0;

        // let the last words through, then stay quiet for a reseed's latency
        while (checker_h.pending_draws.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (checker_h.errors == 0 && checker_h.pending_draws.size() == 0) begin
            $display("xoshiro256pp_rng_with_range_top_tb OK");
        end else begin
            $display("xoshiro256pp_rng_with_range_top_tb NOT OK");
        end
        $finish;
    end

endmodule
